// ===== design/qalu_pkg.sv =====
package qalu_pkg;

  typedef enum logic [2:0] {
    KIND_MUL   = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_CONJ  = 3'd2,
    KIND_SCALE = 3'd3,
    KIND_DOT   = 3'd4,
    KIND_ROT   = 3'd5
  } kind_t;

  // how the product array is summed
  typedef enum logic [1:0] {
    MAC_HAM,
    MAC_DOT,
    MAC_EACH
  } mac_mode_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

endpackage

// ===== design/qalu_mac.sv =====
// 4x4 product array, then signed sums of four products (single products in MAC_EACH) rounded half up.
// Two register stages, both advanced by en.
module qalu_mac #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int F  = 14
) (
  input  logic                          clk,
  input  logic                          en,
  input  qalu_pkg::mac_mode_t           mode,
  input  logic signed [AW-1:0]          a [4],
  input  logic signed [BW-1:0]          b [4],
  output logic signed [AW+BW+1-F:0]     res [4]
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 2;
  localparam int RW = SW - F;
  localparam logic [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (F - 1);

  logic signed [PW-1:0] prod [16];
  qalu_pkg::mac_mode_t  mode_1;
  logic signed [SW-1:0] sum [4];

  function automatic logic signed [RW-1:0] rnd(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = s + $signed(HALF);
    return t[SW-1:F];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[4*i+j] <= a[i] * b[j];
        end
      end
      mode_1 <= mode;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = '0;
    end
    unique case (mode_1)
      qalu_pkg::MAC_HAM: begin
        sum[0] = SW'(prod[0]) - SW'(prod[5]) - SW'(prod[10]) - SW'(prod[15]);
        sum[1] = SW'(prod[1]) + SW'(prod[4]) + SW'(prod[11]) - SW'(prod[14]);
        sum[2] = SW'(prod[2]) - SW'(prod[7]) + SW'(prod[8]) + SW'(prod[13]);
        sum[3] = SW'(prod[3]) + SW'(prod[6]) - SW'(prod[9]) + SW'(prod[12]);
      end
      qalu_pkg::MAC_DOT: begin
        sum[0] = SW'(prod[0]) + SW'(prod[5]) + SW'(prod[10]) + SW'(prod[15]);
      end
      qalu_pkg::MAC_EACH: begin
        // a[i] * b[0]
        sum[0] = SW'(prod[0]);
        sum[1] = SW'(prod[4]);
        sum[2] = SW'(prod[8]);
        sum[3] = SW'(prod[12]);
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          sum[i] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        res[i] <= rnd(sum[i]);
      end
    end
  end

endmodule

// ===== design/quaternion_alu_top.sv =====
// Quaternion ALU: one beat per cycle in and out. Stage 1-2 form the first
// 16-product array and its rounded sums (product, dot, scale, and q*v for
// rotate); stage 3 clips and builds sum and conjugate; stages 4-5 form the
// second array for (q*v)*conj(q); stage 6 is the output register. The whole
// pipe advances together and freezes while a result beat waits on m_tready.
// Results are saturated and m_tuser flags it.
module quaternion_alu_top #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z, scale
  input  logic [((9*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
  // kind
  input  logic [2:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_w, out_x, out_y, out_z
  output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_tdata,
  // saturated
  output logic m_tuser
);

  localparam int W      = COMPONENT_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int RW1    = 2*W + 2 - F;
  localparam int RW2    = 2*W + 3 - F;
  localparam int OUT_DW = ((4*W+7)/8)*8;

  logic adv;
  logic signed [W-1:0] in_q [4];
  logic signed [W-1:0] in_r [4];
  logic signed [W-1:0] in_sc;
  qalu_pkg::kind_t     in_kind;
  logic signed [W-1:0] b_sel [4];
  qalu_pkg::mac_mode_t mode_sel;

  qalu_pkg::ctl_t c1, c2, c3, c4, c5, c6;
  logic signed [W-1:0] q1 [4];
  logic signed [W-1:0] q2 [4];
  logic signed [W-1:0] r1 [4];
  logic signed [W-1:0] r2 [4];
  logic signed [RW1-1:0] m1 [4];
  logic signed [RW2-1:0] m2 [4];

  logic signed [W-1:0] t_next [4];
  logic                sat_next;
  logic signed [W-1:0] t3 [4];
  logic signed [W-1:0] t4 [4];
  logic signed [W-1:0] t5 [4];
  logic signed [W:0]   qc3 [4];
  logic sat3, sat4, sat5;

  logic signed [W-1:0] o_next [4];
  logic                osat_next;
  logic signed [W-1:0] out_w, out_x, out_y, out_z;
  logic                saturated;

  // {clipped, value}
  function automatic logic [W:0] clip(input logic signed [RW2-1:0] v);
    if (v[RW2-1:W-1] == {(RW2-W+1){v[RW2-1]}}) begin
      return {1'b0, v[W-1:0]};
    end else if (v[RW2-1]) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  assign adv      = !c6.valid || m_tready;
  assign s_tready = adv && !rst;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_q[i] = s_tdata[i*W +: W];
      in_r[i] = s_tdata[(4+i)*W +: W];
    end
    in_sc   = s_tdata[8*W +: W];
    in_kind = qalu_pkg::kind_t'(s_tuser);
  end

  // second operand of the first product array
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b_sel[i] = '0;
    end
    mode_sel = qalu_pkg::MAC_EACH;
    unique case (in_kind)
      qalu_pkg::KIND_MUL: begin
        b_sel    = in_r;
        mode_sel = qalu_pkg::MAC_HAM;
      end
      qalu_pkg::KIND_DOT: begin
        b_sel    = in_r;
        mode_sel = qalu_pkg::MAC_DOT;
      end
      qalu_pkg::KIND_ROT: begin
        for (int i = 1; i < 4; i++) begin
          b_sel[i] = in_r[i];
        end
        mode_sel = qalu_pkg::MAC_HAM;
      end
      qalu_pkg::KIND_SCALE: begin
        b_sel[0] = in_sc;
      end
      default: begin
        mode_sel = qalu_pkg::MAC_EACH;
      end
    endcase
  end

  qalu_mac #(.AW(W), .BW(W), .F(F)) u_mac_a (
    .clk  (clk),
    .en   (adv),
    .mode (mode_sel),
    .a    (in_q),
    .b    (b_sel),
    .res  (m1)
  );

  // stage 3: clip first products, or do sum / conjugate
  always_comb begin
    logic [W:0] cl [4];
    for (int i = 0; i < 4; i++) begin
      cl[i] = '0;
    end
    unique case (c2.kind)
      qalu_pkg::KIND_MUL, qalu_pkg::KIND_SCALE, qalu_pkg::KIND_ROT: begin
        for (int i = 0; i < 4; i++) begin
          cl[i] = clip(RW2'(m1[i]));
        end
      end
      qalu_pkg::KIND_ADD: begin
        for (int i = 0; i < 4; i++) begin
          cl[i] = clip(RW2'(q2[i]) + RW2'(r2[i]));
        end
      end
      qalu_pkg::KIND_CONJ: begin
        cl[0] = {1'b0, q2[0]};
        for (int i = 1; i < 4; i++) begin
          cl[i] = clip(-RW2'(q2[i]));
        end
      end
      qalu_pkg::KIND_DOT: begin
        cl[0] = clip(RW2'(m1[0]));
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          cl[i] = '0;
        end
      end
    endcase
    sat_next = 1'b0;
    for (int i = 0; i < 4; i++) begin
      t_next[i] = cl[i][W-1:0];
      sat_next  = sat_next | cl[i][W];
    end
  end

  qalu_mac #(.AW(W), .BW(W+1), .F(F)) u_mac_b (
    .clk  (clk),
    .en   (adv),
    .mode (qalu_pkg::MAC_HAM),
    .a    (t3),
    .b    (qc3),
    .res  (m2)
  );

  // stage 6: finish rotate, pass the rest through
  always_comb begin
    logic [W:0] cl;
    o_next    = t5;
    osat_next = sat5;
    cl        = '0;
    if (c5.kind == qalu_pkg::KIND_ROT) begin
      o_next[0] = '0;
      for (int i = 1; i < 4; i++) begin
        cl        = clip(m2[i]);
        o_next[i] = cl[W-1:0];
        osat_next = osat_next | cl[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (adv) begin
      c1 <= '{valid: s_tvalid, kind: in_kind};
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
      c6 <= c5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1   <= in_q;
      r1   <= in_r;
      q2   <= q1;
      r2   <= r1;
      t3   <= t_next;
      sat3 <= sat_next;
      qc3[0] <= (W+1)'(q2[0]);
      for (int i = 1; i < 4; i++) begin
        qc3[i] <= -((W+1)'(q2[i]));
      end
      t4   <= t3;
      sat4 <= sat3;
      t5   <= t4;
      sat5 <= sat4;
      out_w     <= o_next[0];
      out_x     <= o_next[1];
      out_y     <= o_next[2];
      out_z     <= o_next[3];
      saturated <= osat_next;
    end
  end

  assign m_tvalid = c6.valid;
  assign m_tdata  = OUT_DW'({out_z, out_y, out_x, out_w});
  assign m_tuser  = saturated;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> c1.valid)
    else $error("accepted beat did not enter the pipe");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (c6.valid && !m_tready) |=> $stable(c5) && $stable(c1))
    else $error("pipe moved during output stall");

  a_dot_vector_zero: assert property (@(posedge clk) disable iff (rst)
    (c6.valid && c6.kind == qalu_pkg::KIND_DOT) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("dot result has nonzero vector part");

  a_rot_scalar_zero: assert property (@(posedge clk) disable iff (rst)
    (c6.valid && c6.kind == qalu_pkg::KIND_ROT) |-> (out_w == '0))
    else $error("rotate result has nonzero scalar part");

  a_unused_kind: assert property (@(posedge clk) disable iff (rst)
    (c6.valid && c6.kind > qalu_pkg::KIND_ROT) |->
      (out_w == '0 && out_x == '0 && out_y == '0 && out_z == '0 && !saturated))
    else $error("unused kind gave a nonzero result");
`endif

endmodule
